// ===== rtl/mqd_pkg.sv =====
package mqd_pkg;

    localparam int CONTEXT_BITS = 16;
    localparam int QUEUE_DEPTH  = 8;
    localparam int CTX_COUNT    = 1 << CONTEXT_BITS;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_START  = 2'd1;
    localparam logic [1:0] ACT_DECODE = 2'd2;

    localparam logic [7:0]  BYTE_FF       = 8'hFF;
    localparam logic [7:0]  MARKER_LIMIT  = 8'h8F;
    localparam logic [31:0] STUFF_ADD     = 32'h0000_FE00;
    localparam logic [31:0] BYTE_ADD      = 32'h0000_FF00;
    localparam logic [15:0] INTERVAL_INIT = 16'h8000;
    localparam logic [3:0]  BC_FULL       = 4'd8;
    localparam logic [3:0]  BC_STUFFED    = 4'd7;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  data_byte;
        logic [15:0] context_req;
        logic        clear_contexts;
    } t_in_item;

    typedef struct packed {
        logic decision;
        logic marker_seen;
        logic starved;
    } t_out_item;

    typedef struct packed {
        logic [15:0] qe;
        logic [5:0]  nmps;
        logic [5:0]  nlps;
        logic        sw;
    } t_qe_row;

    typedef struct packed {
        logic [5:0] row;
        logic       mps;
    } t_ctx_entry;

    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       pop;
    } t_queue_req;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] head;
    } t_queue_stat;

    typedef struct packed {
        logic                    rd_en;
        logic [CONTEXT_BITS-1:0] rd_addr;
        logic                    wr_en;
        logic [CONTEXT_BITS-1:0] wr_addr;
        t_ctx_entry              wr_data;
        logic                    clear_start;
    } t_ctx_req;

    typedef struct packed {
        logic [31:0] code;
        logic [7:0]  last;
        logic [3:0]  bc;
        logic        marker;
        logic        pop;
        logic        starved;
    } t_byte_in_res;

    function automatic t_qe_row qe_lookup(input logic [5:0] row);
        t_qe_row r;
        case (row)
            6'd0:  r = '{16'h5601, 6'd1,  6'd1,  1'b1};
            6'd1:  r = '{16'h3401, 6'd2,  6'd6,  1'b0};
            6'd2:  r = '{16'h1801, 6'd3,  6'd9,  1'b0};
            6'd3:  r = '{16'h0AC1, 6'd4,  6'd12, 1'b0};
            6'd4:  r = '{16'h0521, 6'd5,  6'd29, 1'b0};
            6'd5:  r = '{16'h0221, 6'd38, 6'd33, 1'b0};
            6'd6:  r = '{16'h5601, 6'd7,  6'd6,  1'b1};
            6'd7:  r = '{16'h5401, 6'd8,  6'd14, 1'b0};
            6'd8:  r = '{16'h4801, 6'd9,  6'd14, 1'b0};
            6'd9:  r = '{16'h3801, 6'd10, 6'd14, 1'b0};
            6'd10: r = '{16'h3001, 6'd11, 6'd17, 1'b0};
            6'd11: r = '{16'h2401, 6'd12, 6'd18, 1'b0};
            6'd12: r = '{16'h1C01, 6'd13, 6'd20, 1'b0};
            6'd13: r = '{16'h1601, 6'd29, 6'd21, 1'b0};
            6'd14: r = '{16'h5601, 6'd15, 6'd14, 1'b1};
            6'd15: r = '{16'h5401, 6'd16, 6'd14, 1'b0};
            6'd16: r = '{16'h5101, 6'd17, 6'd15, 1'b0};
            6'd17: r = '{16'h4801, 6'd18, 6'd16, 1'b0};
            6'd18: r = '{16'h3801, 6'd19, 6'd17, 1'b0};
            6'd19: r = '{16'h3401, 6'd20, 6'd18, 1'b0};
            6'd20: r = '{16'h3001, 6'd21, 6'd19, 1'b0};
            6'd21: r = '{16'h2801, 6'd22, 6'd19, 1'b0};
            6'd22: r = '{16'h2401, 6'd23, 6'd20, 1'b0};
            6'd23: r = '{16'h2201, 6'd24, 6'd21, 1'b0};
            6'd24: r = '{16'h1C01, 6'd25, 6'd22, 1'b0};
            6'd25: r = '{16'h1801, 6'd26, 6'd23, 1'b0};
            6'd26: r = '{16'h1601, 6'd27, 6'd24, 1'b0};
            6'd27: r = '{16'h1401, 6'd28, 6'd25, 1'b0};
            6'd28: r = '{16'h1201, 6'd29, 6'd26, 1'b0};
            6'd29: r = '{16'h1101, 6'd30, 6'd27, 1'b0};
            6'd30: r = '{16'h0AC1, 6'd31, 6'd28, 1'b0};
            6'd31: r = '{16'h09C1, 6'd32, 6'd29, 1'b0};
            6'd32: r = '{16'h08A1, 6'd33, 6'd30, 1'b0};
            6'd33: r = '{16'h0521, 6'd34, 6'd31, 1'b0};
            6'd34: r = '{16'h0441, 6'd35, 6'd32, 1'b0};
            6'd35: r = '{16'h02A1, 6'd36, 6'd33, 1'b0};
            6'd36: r = '{16'h0221, 6'd37, 6'd34, 1'b0};
            6'd37: r = '{16'h0141, 6'd38, 6'd35, 1'b0};
            6'd38: r = '{16'h0111, 6'd39, 6'd36, 1'b0};
            6'd39: r = '{16'h0085, 6'd40, 6'd37, 1'b0};
            6'd40: r = '{16'h0049, 6'd41, 6'd38, 1'b0};
            6'd41: r = '{16'h0025, 6'd42, 6'd39, 1'b0};
            6'd42: r = '{16'h0015, 6'd43, 6'd40, 1'b0};
            6'd43: r = '{16'h0009, 6'd44, 6'd41, 1'b0};
            6'd44: r = '{16'h0005, 6'd45, 6'd42, 1'b0};
            6'd45: r = '{16'h0001, 6'd45, 6'd43, 1'b0};
            default: r = '{16'h5601, 6'd46, 6'd46, 1'b0};
        endcase
        return r;
    endfunction

    // One byte-input step. A 0xFF already taken in makes the queue head a look-ahead byte.
    function automatic t_byte_in_res byte_in(input logic        marker,
                                             input logic [7:0]  last,
                                             input t_queue_stat q,
                                             input logic [31:0] code);
        t_byte_in_res r;
        logic [7:0]   b;
        r.code    = code;
        r.last    = last;
        r.bc      = BC_FULL;
        r.marker  = marker;
        r.pop     = 1'b0;
        r.starved = 1'b0;
        b         = q.empty ? BYTE_FF : q.head;
        if (marker) begin
            r.bc = BC_FULL;
        end else if (last == BYTE_FF) begin
            if (q.empty) begin
                r.starved = 1'b1;
            end else if (q.head > MARKER_LIMIT) begin
                r.marker = 1'b1;
            end else begin
                r.pop  = 1'b1;
                r.last = q.head;
                r.code = code + STUFF_ADD - {15'h0000, q.head, 9'h000};
                r.bc   = BC_STUFFED;
            end
        end else begin
            r.pop     = ~q.empty;
            r.starved = q.empty;
            r.last    = b;
            r.code    = code + BYTE_ADD - {16'h0000, b, 8'h00};
        end
        return r;
    endfunction

    function automatic logic [4:0] lead_zeros(input logic [15:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd16;
        found = 1'b0;
        for (int i = 15; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 5'(15 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/mq_arithmetic_bit_decoder_top.sv =====
// MQ arithmetic bit decoder. Items enter on the input channel (i_in_valid, o_in_stall,
// i_in_item) and carry an action: push a compressed byte into the eight-entry byte
// queue, start the decoder (optionally clearing every context), or decode one bit.
// Only a decode item produces a result item on the output channel (o_out_valid,
// i_out_stall, o_out_item) with the decision, the marker flag and the starved flag.
// The block works on one item at a time. A push is taken in IDLE; a start passes
// through START1 and START2, which load the first bytes. A decode reads the context
// memory on acceptance, then decides and, except when the MPS path needs no
// renormalization, writes the context back; renormalization steps follow, each
// shifting up to eight bits and loading at most one byte, and then the output
// register is loaded. After reset, and after a start that clears the contexts, the
// context memory is swept one entry per cycle over all 65536 entries, with o_in_stall
// high. The result sits in an output register, so a stalled receiver holds the
// block only when a second result is ready while the first has not been taken.
module mq_arithmetic_bit_decoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  mqd_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output mqd_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    typedef enum logic [2:0] {
        S_WAIT_CLR,
        S_IDLE,
        S_START1,
        S_START2,
        S_DECIDE,
        S_RENORM,
        S_EMIT
    } t_state;

    t_state                           r_state, n_state;
    logic                             r_start_after, n_start_after;
    logic [31:0]                      r_code, n_code;
    logic [15:0]                      r_interval, n_interval;
    logic [3:0]                       r_bc, n_bc;
    logic [7:0]                       r_last, n_last;
    logic                             r_marker, n_marker;
    logic                             r_starved, n_starved;
    logic                             r_decision, n_decision;
    logic [mqd_pkg::CONTEXT_BITS-1:0] r_ctx, n_ctx;
    logic                             r_out_valid, n_out_valid;
    mqd_pkg::t_out_item               r_out_item, n_out_item;

    mqd_pkg::t_queue_req              q_req;
    mqd_pkg::t_queue_stat             q_stat;
    mqd_pkg::t_ctx_req                ctx_req;
    mqd_pkg::t_ctx_entry              ent;
    logic                             ctx_busy;

    logic                             in_accept;
    mqd_pkg::t_qe_row                 qr;
    logic [15:0]                      diff;
    logic                             mps_hit;
    logic                             take_lps;
    mqd_pkg::t_byte_in_res            br;
    logic [4:0]                       lz;
    logic [3:0]                       rn_bc;
    logic [31:0]                      rn_code;
    logic [3:0]                       rn_k;
    logic [7:0]                       first_byte;

    mqd_byte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (q_req),
        .o_stat  (q_stat)
    );

    mqd_ctx_store u_ctx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ctx_req),
        .o_rd_data (ent),
        .o_busy    (ctx_busy)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign qr         = mqd_pkg::qe_lookup(ent.row);
    assign diff       = r_interval - qr.qe;
    assign mps_hit    = (r_code[31:16] < diff);
    assign take_lps   = mps_hit ? (diff < qr.qe) : !(diff < qr.qe);
    assign br         = mqd_pkg::byte_in(r_marker, r_last, q_stat, r_code);
    assign lz         = mqd_pkg::lead_zeros(r_interval);
    assign rn_bc      = (r_bc == 4'd0) ? br.bc : r_bc;
    assign rn_code    = (r_bc == 4'd0) ? br.code : r_code;
    assign rn_k       = ({1'b0, rn_bc} < lz) ? rn_bc : lz[3:0];
    assign first_byte = q_stat.empty ? mqd_pkg::BYTE_FF : q_stat.head;

    always_comb begin
        n_state       = r_state;
        n_start_after = r_start_after;
        n_code        = r_code;
        n_interval    = r_interval;
        n_bc          = r_bc;
        n_last        = r_last;
        n_marker      = r_marker;
        n_starved     = r_starved;
        n_decision    = r_decision;
        n_ctx         = r_ctx;
        n_out_valid   = r_out_valid;
        n_out_item    = r_out_item;
        q_req         = '0;
        ctx_req       = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_WAIT_CLR: begin
                if (!ctx_busy) begin
                    n_state       = r_start_after ? S_START1 : S_IDLE;
                    n_start_after = 1'b0;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    case (i_in_item.action)
                        mqd_pkg::ACT_PUSH: begin
                            q_req.push = 1'b1;
                            q_req.data = i_in_item.data_byte;
                        end
                        mqd_pkg::ACT_START: begin
                            if (i_in_item.clear_contexts) begin
                                ctx_req.clear_start = 1'b1;
                                n_start_after       = 1'b1;
                                n_state             = S_WAIT_CLR;
                            end else begin
                                n_state = S_START1;
                            end
                        end
                        mqd_pkg::ACT_DECODE: begin
                            ctx_req.rd_en   = 1'b1;
                            ctx_req.rd_addr = i_in_item.context_req[mqd_pkg::CONTEXT_BITS-1:0];
                            n_ctx           = i_in_item.context_req[mqd_pkg::CONTEXT_BITS-1:0];
                            n_starved       = 1'b0;
                            n_state         = S_DECIDE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_START1: begin
                q_req.pop = !q_stat.empty;
                n_last    = first_byte;
                n_code    = {8'h00, first_byte ^ mqd_pkg::BYTE_FF, 16'h0000};
                n_marker  = 1'b0;
                n_state   = S_START2;
            end
            S_START2: begin
                q_req.pop  = br.pop;
                n_last     = br.last;
                n_marker   = br.marker;
                n_code     = br.code << 7;
                n_bc       = br.bc - 4'd7;
                n_interval = mqd_pkg::INTERVAL_INIT;
                n_state    = S_IDLE;
            end
            S_DECIDE: begin
                if (mps_hit && diff[15]) begin
                    n_interval = diff;
                    n_decision = ent.mps;
                    n_state    = S_EMIT;
                end else begin
                    ctx_req.wr_en   = 1'b1;
                    ctx_req.wr_addr = r_ctx;
                    if (take_lps) begin
                        n_decision          = ~ent.mps;
                        ctx_req.wr_data.mps = qr.sw ? ~ent.mps : ent.mps;
                        ctx_req.wr_data.row = qr.nlps;
                    end else begin
                        n_decision          = ent.mps;
                        ctx_req.wr_data.mps = ent.mps;
                        ctx_req.wr_data.row = qr.nmps;
                    end
                    if (mps_hit) begin
                        n_interval = diff;
                    end else begin
                        n_code     = r_code - {diff, 16'h0000};
                        n_interval = qr.qe;
                    end
                    n_state = S_RENORM;
                end
            end
            S_RENORM: begin
                if (r_interval[15]) begin
                    n_state = S_EMIT;
                end else begin
                    if (r_bc == 4'd0) begin
                        q_req.pop = br.pop;
                        n_last    = br.last;
                        n_marker  = br.marker;
                        n_starved = r_starved | br.starved;
                    end
                    n_interval = r_interval << rn_k;
                    n_code     = rn_code << rn_k;
                    n_bc       = rn_bc - rn_k;
                    if ({1'b0, rn_k} == lz) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid            = 1'b1;
                    n_out_item.decision    = r_decision;
                    n_out_item.marker_seen = r_marker;
                    n_out_item.starved     = r_starved;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_WAIT_CLR;
            r_start_after <= 1'b0;
            r_code        <= '0;
            r_interval    <= mqd_pkg::INTERVAL_INIT;
            r_bc          <= '0;
            r_last        <= '0;
            r_marker      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_start_after <= n_start_after;
            r_code        <= n_code;
            r_interval    <= n_interval;
            r_bc          <= n_bc;
            r_last        <= n_last;
            r_marker      <= n_marker;
            r_out_valid   <= n_out_valid;
        end
        r_starved  <= n_starved;
        r_decision <= n_decision;
        r_ctx      <= n_ctx;
        r_out_item <= n_out_item;
    end

`ifndef SYNTHESIS
    a_idle_not_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ctx_busy)
        else $error("items taken while the context memory is being cleared");

    a_write_not_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctx_req.wr_en |-> !ctx_busy)
        else $error("context write during the clearing sweep");

    a_start_bit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START2) |=> (r_bc == 4'd0 || r_bc == 4'd1))
        else $error("bit counter out of range after decoder start");

    a_renorm_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RENORM) |-> (r_interval != 16'h0000 && r_bc <= mqd_pkg::BC_FULL))
        else $error("renormalization with an empty interval or bad bit count");
`endif

endmodule

// ===== rtl/mqd_byte_queue.sv =====
module mqd_byte_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mqd_pkg::t_queue_req  i_req,
    output mqd_pkg::t_queue_stat o_stat
);

    logic [7:0]                   r_mem [0:mqd_pkg::QUEUE_DEPTH-1];
    logic [mqd_pkg::QPTR_W-1:0]   r_head;
    logic [mqd_pkg::QPTR_W-1:0]   r_tail;
    logic [mqd_pkg::QCNT_W-1:0]   r_count;
    logic                         push_en;
    logic                         pop_en;
    logic                         full;
    logic                         empty;

    assign full    = (r_count == mqd_pkg::QCNT_W'(mqd_pkg::QUEUE_DEPTH));
    assign empty   = (r_count == '0);
    assign push_en = i_req.push && !full;
    assign pop_en  = i_req.pop && !empty;

    assign o_stat.empty = empty;
    assign o_stat.full  = full;
    assign o_stat.head  = r_mem[r_head];

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_tail] <= i_req.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (push_en) begin
                r_tail <= (r_tail == mqd_pkg::QPTR_W'(mqd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : r_tail + 1'b1;
            end
            if (pop_en) begin
                r_head <= (r_head == mqd_pkg::QPTR_W'(mqd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : r_head + 1'b1;
            end
            case ({push_en, pop_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mqd_pkg::QCNT_W'(mqd_pkg::QUEUE_DEPTH))
        else $error("byte queue count above depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.pop |-> !empty)
        else $error("byte taken from an empty queue");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_en && !pop_en) |=> r_count == mqd_pkg::QCNT_W'($past(r_count) + 1'b1))
        else $error("queue count did not follow a push");
`endif

endmodule

// ===== rtl/mqd_ctx_store.sv =====
module mqd_ctx_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mqd_pkg::t_ctx_req   i_req,
    output mqd_pkg::t_ctx_entry o_rd_data,
    output logic                o_busy
);

    mqd_pkg::t_ctx_entry                r_mem [0:mqd_pkg::CTX_COUNT-1];
    mqd_pkg::t_ctx_entry                r_rd_data;
    logic                               r_clearing;
    logic [mqd_pkg::CONTEXT_BITS-1:0]   r_clr_addr;

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clearing;

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (i_req.clear_start) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == '1) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_IDLE    = 2'd3;
    localparam int         CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [15:0] qe;
        logic [5:0]  on_mps;
        logic [5:0]  on_lps;
        logic        flip;
    } prob_row_t;

    localparam prob_row_t PROB_ROWS [47] = '{
        {16'h5601, 6'd1,  6'd1,  1'b1}, {16'h3401, 6'd2,  6'd6,  1'b0},
        {16'h1801, 6'd3,  6'd9,  1'b0}, {16'h0AC1, 6'd4,  6'd12, 1'b0},
        {16'h0521, 6'd5,  6'd29, 1'b0}, {16'h0221, 6'd38, 6'd33, 1'b0},
        {16'h5601, 6'd7,  6'd6,  1'b1}, {16'h5401, 6'd8,  6'd14, 1'b0},
        {16'h4801, 6'd9,  6'd14, 1'b0}, {16'h3801, 6'd10, 6'd14, 1'b0},
        {16'h3001, 6'd11, 6'd17, 1'b0}, {16'h2401, 6'd12, 6'd18, 1'b0},
        {16'h1C01, 6'd13, 6'd20, 1'b0}, {16'h1601, 6'd29, 6'd21, 1'b0},
        {16'h5601, 6'd15, 6'd14, 1'b1}, {16'h5401, 6'd16, 6'd14, 1'b0},
        {16'h5101, 6'd17, 6'd15, 1'b0}, {16'h4801, 6'd18, 6'd16, 1'b0},
        {16'h3801, 6'd19, 6'd17, 1'b0}, {16'h3401, 6'd20, 6'd18, 1'b0},
        {16'h3001, 6'd21, 6'd19, 1'b0}, {16'h2801, 6'd22, 6'd19, 1'b0},
        {16'h2401, 6'd23, 6'd20, 1'b0}, {16'h2201, 6'd24, 6'd21, 1'b0},
        {16'h1C01, 6'd25, 6'd22, 1'b0}, {16'h1801, 6'd26, 6'd23, 1'b0},
        {16'h1601, 6'd27, 6'd24, 1'b0}, {16'h1401, 6'd28, 6'd25, 1'b0},
        {16'h1201, 6'd29, 6'd26, 1'b0}, {16'h1101, 6'd30, 6'd27, 1'b0},
        {16'h0AC1, 6'd31, 6'd28, 1'b0}, {16'h09C1, 6'd32, 6'd29, 1'b0},
        {16'h08A1, 6'd33, 6'd30, 1'b0}, {16'h0521, 6'd34, 6'd31, 1'b0},
        {16'h0441, 6'd35, 6'd32, 1'b0}, {16'h02A1, 6'd36, 6'd33, 1'b0},
        {16'h0221, 6'd37, 6'd34, 1'b0}, {16'h0141, 6'd38, 6'd35, 1'b0},
        {16'h0111, 6'd39, 6'd36, 1'b0}, {16'h0085, 6'd40, 6'd37, 1'b0},
        {16'h0049, 6'd41, 6'd38, 1'b0}, {16'h0025, 6'd42, 6'd39, 1'b0},
        {16'h0015, 6'd43, 6'd40, 1'b0}, {16'h0009, 6'd44, 6'd41, 1'b0},
        {16'h0005, 6'd45, 6'd42, 1'b0}, {16'h0001, 6'd45, 6'd43, 1'b0},
        {16'h5601, 6'd46, 6'd46, 1'b0}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    mqd_pkg::t_in_item  in_item;
    logic               in_stall;
    logic               out_valid;
    mqd_pkg::t_out_item out_item;
    logic               out_stall;

    logic        gaps_on = 1'b0;
    logic        stall_on = 1'b0;
    logic        stream_after_ff = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    logic [31:0]        code_reg = '0;
    logic [15:0]        interval_reg = mqd_pkg::INTERVAL_INIT;
    logic [3:0]         bit_cnt = '0;
    logic [7:0]         last_byte = '0;
    logic               marker_flag = 1'b0;
    logic               starved_now = 1'b0;
    logic [7:0]         byte_fifo [$];
    logic [6:0]         ctx_state [int unsigned];
    mqd_pkg::t_out_item pending_results [$];
    mqd_pkg::t_out_item want_item;

    mq_arithmetic_bit_decoder_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] take_byte();
        if (byte_fifo.size() == 0) begin
            starved_now = 1'b1;
            return mqd_pkg::BYTE_FF;
        end
        return byte_fifo.pop_front();
    endfunction

    function automatic void load_byte();
        logic [7:0] b;
        if (marker_flag) begin
            bit_cnt = mqd_pkg::BC_FULL;
            return;
        end
        if (last_byte == mqd_pkg::BYTE_FF) begin
            if (byte_fifo.size() == 0) begin
                starved_now = 1'b1;
                bit_cnt     = mqd_pkg::BC_FULL;
                return;
            end
            b = byte_fifo[0];
            if (b > mqd_pkg::MARKER_LIMIT) begin
                marker_flag = 1'b1;
                bit_cnt     = mqd_pkg::BC_FULL;
            end else begin
                void'(byte_fifo.pop_front());
                last_byte = b;
                code_reg  = code_reg + mqd_pkg::STUFF_ADD - ({24'h000000, b} << 9);
                bit_cnt   = mqd_pkg::BC_STUFFED;
            end
        end else begin
            b         = take_byte();
            last_byte = b;
            code_reg  = code_reg + mqd_pkg::BYTE_ADD - ({24'h000000, b} << 8);
            bit_cnt   = mqd_pkg::BC_FULL;
        end
    endfunction

    function automatic void start_decoder(input logic clear_all);
        logic [7:0] b;
        if (clear_all) begin
            ctx_state.delete();
        end
        marker_flag  = 1'b0;
        b            = take_byte();
        last_byte    = b;
        code_reg     = {8'h00, b ^ 8'hFF, 16'h0000};
        load_byte();
        code_reg     = code_reg << 7;
        bit_cnt      = bit_cnt - 4'd7;
        interval_reg = mqd_pkg::INTERVAL_INIT;
    endfunction

    function automatic logic decode_decision(input logic [mqd_pkg::CONTEXT_BITS-1:0] ctx);
        logic [6:0] entry;
        logic [5:0] row;
        logic [5:0] next_row;
        logic       mps;
        logic       d;
        logic [15:0] qe;
        int         guard;
        entry = ctx_state.exists(ctx) ? ctx_state[ctx] : 7'h00;
        row   = entry[6:1];
        mps   = entry[0];
        d     = mps;
        if (row > 6'd46) begin
            row = 6'd46;
        end
        qe           = PROB_ROWS[row].qe;
        interval_reg = interval_reg - qe;
        if (code_reg[31:16] < interval_reg) begin
            if (interval_reg[15]) begin
                return d;
            end
            if (interval_reg < qe) begin
                d        = ~mps;
                mps      = PROB_ROWS[row].flip ? ~mps : mps;
                next_row = PROB_ROWS[row].on_lps;
            end else begin
                next_row = PROB_ROWS[row].on_mps;
            end
        end else begin
            code_reg = code_reg - {interval_reg, 16'h0000};
            if (interval_reg < qe) begin
                next_row = PROB_ROWS[row].on_mps;
            end else begin
                d        = ~mps;
                mps      = PROB_ROWS[row].flip ? ~mps : mps;
                next_row = PROB_ROWS[row].on_lps;
            end
            interval_reg = qe;
        end
        ctx_state[ctx] = {next_row, mps};
        guard = 0;
        do begin
            if (bit_cnt == 4'd0) begin
                load_byte();
            end
            interval_reg = interval_reg << 1;
            code_reg     = code_reg << 1;
            bit_cnt      = bit_cnt - 4'd1;
            guard++;
        end while (!interval_reg[15] && guard < 16);
        return d;
    endfunction

    function automatic void predict_item(input mqd_pkg::t_in_item it);
        mqd_pkg::t_out_item r;
        starved_now = 1'b0;
        case (it.action)
            mqd_pkg::ACT_PUSH: begin
                if (byte_fifo.size() < mqd_pkg::QUEUE_DEPTH) begin
                    byte_fifo.push_back(it.data_byte);
                end
            end
            mqd_pkg::ACT_START: begin
                start_decoder(it.clear_contexts);
            end
            mqd_pkg::ACT_DECODE: begin
                r.decision    = decode_decision(it.context_req[mqd_pkg::CONTEXT_BITS-1:0]);
                r.marker_seen = marker_flag;
                r.starved     = starved_now;
                pending_results.push_back(r);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic mqd_pkg::t_in_item make_item(input logic [1:0] act,
                                                    input logic [7:0] data,
                                                    input logic [15:0] ctx,
                                                    input logic clr);
        mqd_pkg::t_in_item it;
        it.action         = act;
        it.data_byte      = data;
        it.context_req    = ctx;
        it.clear_contexts = clr;
        return it;
    endfunction

    function automatic mqd_pkg::t_in_item random_item(input logic [1:0] act);
        return make_item(act, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [7:0] stream_byte();
        logic [7:0] b;
        if (stream_after_ff) begin
            if ($urandom_range(0, 9) == 0) begin
                b = 8'($urandom_range(8'h90, 8'hFF));
            end else begin
                b = 8'($urandom_range(8'h00, 8'h8F));
            end
        end else if ($urandom_range(0, 6) == 0) begin
            b = mqd_pkg::BYTE_FF;
        end else begin
            b = 8'($urandom_range(0, 255));
        end
        stream_after_ff = (b == mqd_pkg::BYTE_FF);
        return b;
    endfunction

    task automatic send_item(input mqd_pkg::t_in_item it);
        int gap;
        gap = gaps_on ? pick_idle_len() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do begin
            @(posedge clk);
        end while (in_stall);
        predict_item(it);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected item, expected none, actual %p", $time, out_item);
            end else begin
                want_item = pending_results.pop_front();
                if (out_item.decision !== want_item.decision) begin
                    mismatch_count++;
                    $display("%0t: decision expected %0b, actual %0b", $time,
                             want_item.decision, out_item.decision);
                end
                if (out_item.marker_seen !== want_item.marker_seen) begin
                    mismatch_count++;
                    $display("%0t: marker_seen expected %0b, actual %0b", $time,
                             want_item.marker_seen, out_item.marker_seen);
                end
                if (out_item.starved !== want_item.starved) begin
                    mismatch_count++;
                    $display("%0t: starved expected %0b, actual %0b", $time,
                             want_item.starved, out_item.starved);
                end
            end
        end
    end

    initial begin : out_stall_driver
        int n;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            n = stall_on ? pick_idle_len() : 0;
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic test_directed_cases();
        logic [7:0] seed_bytes [9] = '{8'h00, 8'hFF, 8'h8F, 8'hFF, 8'h90,
                                        8'h12, 8'h34, 8'h56, 8'h78};
        send_item(make_item(mqd_pkg::ACT_DECODE, 8'h00, 16'h0000, 1'b0));
        send_item(make_item(ACT_IDLE, 8'h00, 16'h0000, 1'b0));
        foreach (seed_bytes[i]) begin
            send_item(make_item(mqd_pkg::ACT_PUSH, seed_bytes[i], 16'h0000, 1'b1));
        end
        send_item(make_item(mqd_pkg::ACT_START, 8'h00, 16'h0000, 1'b0));
        for (int i = 0; i < 5; i++) begin
            send_item(make_item(mqd_pkg::ACT_DECODE, 8'hFF,
                                (i % 2) ? 16'h0000 : 16'hFFFF, 1'b1));
        end
        send_item(make_item(mqd_pkg::ACT_START, 8'hFF, 16'hFFFF, 1'b1));
        send_item(make_item(mqd_pkg::ACT_DECODE, 8'h00, 16'hFFFF, 1'b0));
        send_item(make_item(mqd_pkg::ACT_PUSH, 8'hFF, 16'hFFFF, 1'b0));
        send_item(make_item(mqd_pkg::ACT_START, 8'h00, 16'h0000, 1'b0));
        send_item(make_item(mqd_pkg::ACT_DECODE, 8'h00, 16'h0000, 1'b0));
        send_item(make_item(mqd_pkg::ACT_DECODE, 8'h00, 16'h8000, 1'b0));
        send_item(make_item(ACT_IDLE, 8'hFF, 16'hFFFF, 1'b1));
    endtask

    task automatic run_streams(input int n_items, input bit clear_first, input bit wide_ctx);
        int                counted;
        int                frame_len;
        int                push_pct;
        int                r;
        bit                first;
        logic [15:0]       pool [4];
        mqd_pkg::t_in_item it;
        counted = 0;
        first   = 1'b1;
        while (counted < n_items) begin
            foreach (pool[k]) begin
                pool[k] = 16'($urandom_range(0, 65535));
            end
            case ($urandom_range(0, 2))
                0:       push_pct = 8;
                1:       push_pct = 25;
                default: push_pct = 45;
            endcase
            frame_len = $urandom_range(10, 60);
            repeat ($urandom_range(2, 8)) begin
                it           = random_item(mqd_pkg::ACT_PUSH);
                it.data_byte = stream_byte();
                send_item(it);
                counted++;
            end
            it                = random_item(mqd_pkg::ACT_START);
            it.clear_contexts = clear_first && first;
            first             = 1'b0;
            send_item(it);
            counted++;
            repeat (frame_len) begin
                r = $urandom_range(0, 99);
                if (r < push_pct) begin
                    it           = random_item(mqd_pkg::ACT_PUSH);
                    it.data_byte = stream_byte();
                    send_item(it);
                    counted++;
                end else if (r < 92) begin
                    it = random_item(mqd_pkg::ACT_DECODE);
                    if (!wide_ctx && $urandom_range(0, 9) != 0) begin
                        it.context_req = pool[$urandom_range(0, 3)];
                    end
                    send_item(it);
                    counted++;
                end else if (r < 97) begin
                    send_item(random_item(ACT_IDLE));
                end else begin
                    it                = random_item(mqd_pkg::ACT_START);
                    it.clear_contexts = 1'b0;
                    send_item(it);
                    counted++;
                end
            end
        end
    endtask

    task automatic test_streams_back_to_back();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        run_streams(300, 1'b1, 1'b0);
    endtask

    task automatic test_streams_with_idling();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        run_streams(560, 1'b1, 1'b0);
    endtask

    task automatic test_wide_contexts();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        run_streams(140, 1'b0, 1'b1);
    endtask

    initial begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_streams_back_to_back();
        test_streams_with_idling();
        test_wide_contexts();

        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
